/* rtl/core/mnpt_pkg.sv */
// Package with the shared types and constants of the monophonic note priority tracker.
package mnpt_pkg;

    // Width of a MIDI note number and the low tracker's value when no note is held.
    localparam int NOTE_W = 7;
    localparam logic [NOTE_W-1:0] NOTE_TOP = 7'd127;

    // Width of the held count.
    localparam int COUNT_W = 8;

    // Event kinds.
    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    // Priority modes; the spare code behaves as last pressed.
    localparam logic [1:0] MODE_LOWEST  = 2'd0;
    localparam logic [1:0] MODE_HIGHEST = 2'd1;
    localparam logic [1:0] MODE_LAST    = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_PRIORITY_MODE = 1'b0;
    localparam logic REG_LEGATO_ENABLE = 1'b1;

    // Voice actions.
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_GLIDE   = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* rtl/core/mnpt_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module mnpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/mono_note_priority_tracker_core.sv */
// Top level of the monophonic note priority tracker: sequencer, trackers and config port.
//
//  Channel   Direction  Handshake              Payload
//  input     in         i_in_valid/o_in_ready   i_command, i_note_number
//  result    out        o_out_valid/i_out_ready o_voice_action, o_target_note, o_held_count
//  config    in         APB psel/penable        paddr, pwdata, prdata, pready
//
// Each note entry holds its press order; a nonzero entry marks a held note.
// A note-on or a duplicate passes through S_LOOK and S_DONE before the result is registered;
// a note number at or above NOTE_COUNT skips the lookup and goes straight to S_DONE.
// Releasing a held note rescans the whole map through the RAM read port, one entry a cycle.
// After reset a clearing pass writes every entry to zero, during which no request is taken;
// configuration writes are taken in every sequencer state.
// A waiting result sits in the output register while the next request is taken; a stalled
// output holds the sequencer in its final state until the register frees.
module mono_note_priority_tracker_core #(
    parameter int NOTE_COUNT = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [mnpt_pkg::NOTE_W-1:0] i_note_number,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_voice_action,
    output logic [mnpt_pkg::NOTE_W-1:0] o_target_note,
    output logic [mnpt_pkg::COUNT_W-1:0] o_held_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import mnpt_pkg::*;

    localparam int AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
    localparam int CW = $clog2(NOTE_COUNT + 1);
    localparam logic [CW-1:0] ADDR_END = CW'(NOTE_COUNT);
    localparam logic [COUNT_W-1:0] NOTE_LIMIT = COUNT_W'(NOTE_COUNT);

    // Control and tracker state.
    t_state              r_state, n_state;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_sv, n_sv;
    logic                r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]  r_total, n_total;
    logic [NOTE_W-1:0]   r_low, n_low;
    logic [NOTE_W-1:0]   r_high, n_high;
    logic [NOTE_W-1:0]   r_last, n_last;
    logic [1:0]          r_mode;
    logic                r_legato;

    // Request and scan working registers.
    logic                r_cmd, n_cmd;
    logic [NOTE_W-1:0]   r_note, n_note;
    t_action             r_act, n_act;
    logic [NOTE_W-1:0]   r_tgt, n_tgt;
    logic                r_post, n_post;
    logic [AW-1:0]       r_sidx, n_sidx;
    logic                r_found, n_found;
    logic [AW-1:0]       r_slow, n_slow;
    logic [AW-1:0]       r_shigh, n_shigh;
    logic [COUNT_W-1:0]  r_best, n_best;
    logic [AW-1:0]       r_slast, n_slast;
    logic                r_res_hi, n_res_hi;
    logic                r_res_last, n_res_last;
    t_action             r_out_act, n_out_act;
    logic [NOTE_W-1:0]   r_out_tgt, n_out_tgt;
    logic [COUNT_W-1:0]  r_out_cnt, n_out_cnt;

    // RAM ports.
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COUNT_W-1:0]  wr_data;
    logic [AW-1:0]       rd_addr;
    logic [COUNT_W-1:0]  rd_data;

    logic                cfg_wr;
    logic                out_free;
    logic                held;
    logic [COUNT_W-1:0]  total_inc;
    logic [NOTE_W-1:0]   prio_note;

    mnpt_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NOTE_COUNT)
    ) u_order_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Configuration port: writes complete in the access phase, reads are combinational.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_LEGATO_ENABLE) ? {31'd0, r_legato} : {30'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LOWEST;
            r_legato <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PRIORITY_MODE) begin
                r_mode <= pwdata[1:0];
            end else begin
                r_legato <= pwdata[0];
            end
        end
    end

    // Priority note from the current trackers.
    always_comb begin
        case (r_mode)
            MODE_LOWEST:  prio_note = r_low;
            MODE_HIGHEST: prio_note = r_high;
            default:      prio_note = r_last;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign held       = (rd_data != '0);
    assign total_inc  = r_total + COUNT_W'(1);

    // Sequencer: next state, tracker updates and RAM control.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_sv        = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_total     = r_total;
        n_low       = r_low;
        n_high      = r_high;
        n_last      = r_last;
        n_cmd       = r_cmd;
        n_note      = r_note;
        n_act       = r_act;
        n_tgt       = r_tgt;
        n_post      = r_post;
        n_sidx      = r_sidx;
        n_found     = r_found;
        n_slow      = r_slow;
        n_shigh     = r_shigh;
        n_best      = r_best;
        n_slast     = r_slast;
        n_res_hi    = r_res_hi;
        n_res_last  = r_res_last;
        n_out_act   = r_out_act;
        n_out_tgt   = r_out_tgt;
        n_out_cnt   = r_out_cnt;
        wr_en       = 1'b0;
        wr_addr     = r_note[AW-1:0];
        wr_data     = '0;
        rd_addr     = r_addr[AW-1:0];

        unique case (r_state)
            // Zero every entry once after reset.
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr[AW-1:0];
                n_addr  = r_addr + CW'(1);
                if (r_addr == ADDR_END - CW'(1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a request and look up its entry.
            S_IDLE: begin
                rd_addr = i_note_number[AW-1:0];
                if (i_in_valid) begin
                    n_cmd  = i_command;
                    n_note = i_note_number;
                    n_act  = ACT_NONE;
                    n_tgt  = '0;
                    n_post = 1'b0;
                    if ({1'b0, i_note_number} < NOTE_LIMIT) begin
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // The entry is on the read port: press, release or ignore.
            S_LOOK: begin
                n_state = S_DONE;
                if (r_cmd == CMD_NOTE_ON && !held) begin
                    wr_en   = 1'b1;
                    wr_data = total_inc;
                    n_total = total_inc;
                    if (r_note < r_low) begin
                        n_low = r_note;
                    end
                    if (r_note > r_high) begin
                        n_high = r_note;
                    end
                    n_last = r_note;
                    n_act  = (r_legato && total_inc > COUNT_W'(1)) ? ACT_GLIDE : ACT_TRIGGER;
                    n_tgt  = r_note;
                end else if (r_cmd == CMD_NOTE_OFF && held) begin
                    wr_en      = 1'b1;
                    n_total    = r_total - COUNT_W'(1);
                    n_post     = 1'b1;
                    n_res_hi   = (r_note == r_high);
                    n_res_last = (r_note == r_last);
                    n_addr     = '0;
                    n_found    = 1'b0;
                    n_slow     = '0;
                    n_shigh    = '0;
                    n_best     = '0;
                    n_slast    = '0;
                    n_state    = S_SCAN;
                end
            end

            // Walk the map in ascending order, one read issued and one entry checked a cycle.
            S_SCAN: begin
                if (r_sv) begin
                    if (held && !r_found) begin
                        n_found = 1'b1;
                        n_slow  = r_sidx;
                    end
                    if (held) begin
                        n_shigh = r_sidx;
                    end
                    if (rd_data > r_best) begin
                        n_best  = rd_data;
                        n_slast = r_sidx;
                    end
                end
                if (r_addr != ADDR_END) begin
                    n_addr = r_addr + CW'(1);
                    n_sv   = 1'b1;
                    n_sidx = r_addr[AW-1:0];
                end else if (!r_sv) begin
                    n_low = r_found ? NOTE_W'(r_slow) : NOTE_TOP;
                    if (r_res_hi) begin
                        n_high = r_found ? NOTE_W'(r_shigh) : '0;
                    end
                    if (r_res_last) begin
                        n_last = (r_best != '0) ? NOTE_W'(r_slast) : '0;
                    end
                    n_state = S_DONE;
                end
            end

            // Load the result once the output register is free.
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_total;
                    if (r_post && r_total == '0) begin
                        n_out_act = ACT_RELEASE;
                        n_out_tgt = r_note;
                    end else if (r_post) begin
                        n_out_act = ACT_GLIDE;
                        n_out_tgt = prio_note;
                    end else begin
                        n_out_act = r_act;
                        n_out_tgt = r_tgt;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and trackers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_sv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_low       <= NOTE_TOP;
            r_high      <= '0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_sv        <= n_sv;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_low       <= n_low;
            r_high      <= n_high;
            r_last      <= n_last;
        end
    end

    // Request, scan and output payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_note     <= n_note;
        r_act      <= n_act;
        r_tgt      <= n_tgt;
        r_post     <= n_post;
        r_sidx     <= n_sidx;
        r_found    <= n_found;
        r_slow     <= n_slow;
        r_shigh    <= n_shigh;
        r_best     <= n_best;
        r_slast    <= n_slast;
        r_res_hi   <= n_res_hi;
        r_res_last <= n_res_last;
        r_out_act  <= n_out_act;
        r_out_tgt  <= n_out_tgt;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_out_valid    = r_out_valid;
    assign o_voice_action = r_out_act;
    assign o_target_note  = r_out_tgt;
    assign o_held_count   = r_out_cnt;

endmodule
